// ===== hw/rtl/ptcs_pkg.sv =====
// Shared widths, command and register codes, and types for the periodic
// tick compare scheduler. No dependencies.
`default_nettype none

package ptcs_pkg;

  localparam int unsigned CNT_W    = 64;   // counter and compare width
  localparam int unsigned PER_W    = 32;   // tick period width
  localparam int unsigned NSEC_W   = 40;   // scaled ns-per-cycle width
  localparam int unsigned CPU_W    = 8;    // processor number width
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned TCK_W    = 16;   // saturating tick counts
  localparam int unsigned ACC_W    = CNT_W + NSEC_W;
  localparam int unsigned OUT_W    = 2 * CNT_W + 2 * TCK_W + 2;
  localparam int unsigned OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [PER_W-1:0]  PERIOD_RST = PER_W'(1000000);
  localparam logic [NSEC_W-1:0] NSEC_RST   = NSEC_W'(64'd1073741824);
  localparam logic [CPU_W-1:0]  CPU_RST    = '0;

  // q + 2 saturates once q reaches this
  localparam logic [CNT_W-1:0]  QUOT_SAT   = CNT_W'(65533);

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [IDX_W-1:0] REG_NSEC_CYCLE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CPU_INDEX   = 2'd2;

  typedef struct packed {
    logic             went_backwards;
    logic [CNT_W-1:0] nsec_offset;
    logic             early_tick;
    logic [TCK_W-1:0] ticks_dropped;
    logic [TCK_W-1:0] ticks_counted;
    logic [CNT_W-1:0] compare_value;
  } res_t;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_START_MUL = 12'b0000_0000_0010,
    ST_START_FIN = 12'b0000_0000_0100,
    ST_TICK      = 12'b0000_0000_1000,
    ST_TICK_DIV  = 12'b0000_0001_0000,
    ST_TICK_FIN  = 12'b0000_0010_0000,
    ST_TICK_OUT  = 12'b0000_0100_0000,
    ST_RD        = 12'b0000_1000_0000,
    ST_RD_MUL    = 12'b0001_0000_0000,
    ST_RD_ACC    = 12'b0010_0000_0000,
    ST_RD_FIN    = 12'b0100_0000_0000,
    ST_ZERO      = 12'b1000_0000_0000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/ptcs_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend by
// 32-bit divisor. Uses ptcs_pkg widths.
`default_nettype none

module ptcs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ptcs_pkg::CNT_W-1:0] dividend_i,
  input  logic [ptcs_pkg::PER_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ptcs_pkg::CNT_W-1:0] quot_o,
  output logic [ptcs_pkg::PER_W-1:0] rem_o
);
  import ptcs_pkg::*;

  localparam int unsigned CW = $clog2(CNT_W);
  localparam logic [CW-1:0] LAST = CW'(CNT_W - 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0] dq_q, dq_d;
  logic [PER_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [PER_W:0]   trial, diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_q, dq_q[CNT_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[CNT_W-2:0], ge};
      rem_d = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_tick_compare_scheduler_core.sv =====
// Periodic tick compare scheduler: sequencer, shared 32x32 multiplier and
// accumulator, output register. Depends on ptcs_pkg and ptcs_div.
`default_nettype none

// One item at a time; s_axis_tready is high only while the sequencer is idle,
// and a finished result waits in the output register without blocking the
// next item. A start passes a multiply state and a finish state; a tick goes
// straight to its finish and output states when the sample is still short of
// one period past the compare, otherwise through the divider first (one
// quotient bit per cycle over 64 bits); a read answers at once when the
// counter is behind the last tick, otherwise it forms four partial products
// through one 32x32 multiplier, then accumulates and clamps; cmd 3 returns all
// zeros. While the output register is still held by the receiver, an item waits in its last state.
// Config writes take effect at once; issue them only while the block is idle.
module periodic_tick_compare_scheduler_core #(
  parameter int unsigned OFFSET_SHIFT = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ptcs_pkg::CNT_W-1:0]    s_axis_tdata,   // counter_now
  input  logic [ptcs_pkg::CMD_W-1:0]    s_axis_tuser,   // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // compare_value, ticks_counted, ticks_dropped, early_tick, nsec_offset,
  // went_backwards, zero fill
  output logic [ptcs_pkg::OUT_TD_W-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [ptcs_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [ptcs_pkg::NSEC_W-1:0]   cfg_data_i
);
  import ptcs_pkg::*;

  state_e state_q, state_d;

  logic [PER_W-1:0]  period_q;
  logic [NSEC_W-1:0] nsec_q;
  logic [CPU_W-1:0]  cpu_q;

  logic [CNT_W-1:0] nc_q, nc_d, lo_q, lo_d, now_q, now_d, el_q, el_d;
  logic             early_q, early_d, neg_q, neg_d;
  logic [TCK_W-1:0] kc_q, kc_d;
  logic [ACC_W-1:0] acc_q, acc_d, addend;
  logic [1:0]       step_q, step_d, pstep_q;
  logic [CNT_W-1:0] prod_q;
  logic [PER_W-1:0] mul_a, mul_b;

  logic             out_valid_q, out_valid_d, slot_free, emit;
  res_t             out_q, res;

  logic [PER_W-1:0] d;
  logic [2:0]       msb;
  logic [CPU_W-1:0] cpu_low, stag_m;
  logic [CNT_W-1:0] stagger, x, y, el, off, ahead;
  logic [ACC_W-1:0] acc_sh;
  logic             div_start, div_done;
  logic [CNT_W-1:0] div_quot;
  logic [PER_W-1:0] div_rem;

  assign d = (period_q == '0) ? PER_W'(1) : period_q;

  // highest set bit of the processor number
  always_comb begin
    msb = '0;
    for (int i = 0; i < CPU_W; i++) begin
      if (cpu_q[i]) msb = 3'(i);
    end
  end
  assign cpu_low = cpu_q & ~(CPU_W'(1) << msb);
  assign stag_m  = {cpu_low[CPU_W-2:0], 1'b1};
  assign stagger = (cpu_q == '0) ? '0 : (prod_q >> ({1'b0, msb} + 4'd1));

  assign x     = now_q - nc_q - CNT_W'(d);
  assign y     = now_q + CNT_W'(d[PER_W-1:1]) - nc_q;
  assign el    = now_q - nc_q + CNT_W'(d);
  assign ahead = nc_q - now_q;

  assign acc_sh = acc_q >> OFFSET_SHIFT;
  assign off    = (|acc_sh[ACC_W-1:CNT_W]) ? '1 : acc_sh[CNT_W-1:0];

  // shared multiplier operand select; start operands stay up while the result waits
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_START_MUL || state_q == ST_START_FIN) begin
      mul_a = PER_W'(stag_m);
      mul_b = d;
    end else if (state_q == ST_RD_MUL) begin
      mul_a = step_q[1] ? el_q[CNT_W-1:PER_W] : el_q[PER_W-1:0];
      mul_b = step_q[0] ? PER_W'(nsec_q[NSEC_W-1:PER_W]) : nsec_q[PER_W-1:0];
    end
  end

  always_comb begin
    case (pstep_q)
      2'd0:    addend = ACC_W'(prod_q);
      2'd1,
      2'd2:    addend = ACC_W'({prod_q, {PER_W{1'b0}}});
      default: addend = {prod_q[ACC_W-CNT_W-1:0], {CNT_W{1'b0}}};
    endcase
  end

  ptcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x),
    .divisor_i  (d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    nc_d      = nc_q;
    lo_d      = lo_q;
    now_d     = now_q;
    el_d      = el_q;
    early_d   = early_q;
    neg_d     = neg_q;
    kc_d      = kc_q;
    acc_d     = acc_q;
    step_d    = step_q;
    div_start = 1'b0;
    emit      = 1'b0;
    res       = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          now_d = s_axis_tdata;
          case (s_axis_tuser)
            CMD_START: state_d = ST_START_MUL;
            CMD_TICK:  state_d = ST_TICK;
            CMD_READ:  state_d = ST_RD;
            default:   state_d = ST_ZERO;
          endcase
        end
      end
      ST_START_MUL: state_d = ST_START_FIN;
      ST_START_FIN: begin
        emit              = 1'b1;
        res.compare_value = now_q + CNT_W'(d) + stagger;
        if (slot_free) begin
          nc_d    = res.compare_value;
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        early_d = ~ahead[CNT_W-1];
        neg_d   = x[CNT_W-1];
        if (x[CNT_W-1]) begin
          state_d = ST_TICK_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_TICK_DIV;
        end
      end
      ST_TICK_DIV: begin
        if (div_done) state_d = ST_TICK_FIN;
      end
      ST_TICK_FIN: begin
        if (neg_q) begin
          nc_d = nc_q + CNT_W'(d);
          kc_d = TCK_W'(1);
        end else begin
          nc_d = now_q - CNT_W'(div_rem) + CNT_W'(d);
          kc_d = (div_quot >= QUOT_SAT) ? '1 : div_quot[TCK_W-1:0] + TCK_W'(2);
        end
        state_d = ST_TICK_OUT;
      end
      ST_TICK_OUT: begin
        // compare is pushed one period on unless it already lies over half a period past the sample
        emit              = 1'b1;
        res.compare_value = nc_q + (y[CNT_W-1] ? '0 : CNT_W'(d));
        res.ticks_counted = kc_q;
        res.ticks_dropped = {{(TCK_W-1){1'b0}}, ~y[CNT_W-1]};
        res.early_tick    = early_q;
        if (slot_free) begin
          lo_d    = '0;
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        el_d = el;
        if (el[CNT_W-1]) begin
          emit               = 1'b1;
          res.nsec_offset    = lo_q;
          res.went_backwards = 1'b1;
          if (slot_free) state_d = ST_IDLE;
        end else begin
          acc_d   = '0;
          step_d  = '0;
          state_d = ST_RD_MUL;
        end
      end
      ST_RD_MUL: begin
        if (step_q != 2'd0) acc_d = acc_q + addend;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = ST_RD_ACC;
      end
      ST_RD_ACC: begin
        acc_d   = acc_q + addend;
        state_d = ST_RD_FIN;
      end
      ST_RD_FIN: begin
        emit            = 1'b1;
        res.nsec_offset = (off <= lo_q) ? lo_q : off;
        if (slot_free) begin
          lo_d    = res.nsec_offset;
          state_d = ST_IDLE;
        end
      end
      ST_ZERO: begin
        emit = 1'b1;
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit && slot_free) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      period_q    <= PERIOD_RST;
      nsec_q      <= NSEC_RST;
      cpu_q       <= CPU_RST;
      nc_q        <= '0;
      lo_q        <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nc_q        <= nc_d;
      lo_q        <= lo_d;
      step_q      <= step_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TICK_PERIOD: period_q <= cfg_data_i[PER_W-1:0];
          REG_NSEC_CYCLE:  nsec_q   <= cfg_data_i;
          REG_CPU_INDEX:   cpu_q    <= cfg_data_i[CPU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    el_q    <= el_d;
    early_q <= early_d;
    neg_q   <= neg_d;
    kc_q    <= kc_d;
    acc_q   <= acc_d;
    pstep_q <= step_q;
    prod_q  <= CNT_W'(mul_a) * CNT_W'(mul_b);
    if (emit && slot_free) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TD_W'(out_q);

endmodule

`default_nettype wire
